### rtl/core/wbrn_pkg.sv
// Shared types and constants for the waveform baseline rms noise block.
// Used by the front end, the record queue, the back end and the top level.
// No dependencies.
package wbrn_pkg;

  localparam int MAX_SAMPLES  = 4096;
  localparam int SAMPLE_BITS  = 16;
  localparam int TIME_BITS    = 32;
  localparam int CNT_W        = 13;
  localparam int S1_W         = 29;
  localparam int S2_W         = 43;
  localparam int SQ_W         = 31;
  localparam int RMS_W        = 19;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SAMPLES);
  localparam logic [RMS_W-1:0] RMS_MAX   = {RMS_W{1'b1}};

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_FIRST = 2'd1;
  localparam logic [1:0] REG_START = 2'd2;
  localparam logic [1:0] REG_END   = 2'd3;

  localparam logic MODE_FIRST  = 1'b0;
  localparam logic MODE_WINDOW = 1'b1;

  typedef struct packed {
    logic                 select_mode;
    logic [CNT_W-1:0]     first_count;
    logic [TIME_BITS-1:0] window_start;
    logic [TIME_BITS-1:0] window_end;
  } cfg_t;

  // per-waveform statistics handed from front to back
  typedef struct packed {
    logic signed [S1_W-1:0] value_sum;
    logic [S2_W-1:0]        square_sum;
    logic [CNT_W-1:0]       count;
    logic                   short_wave;
  } rec_t;

endpackage

### rtl/core/wbrn_queue.sv
// Short record queue between the accumulating front end and the back end.
// Depends on wbrn_pkg (rec_t, depth constants).
module wbrn_queue import wbrn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rec_t              push_rec,
  input  logic              pop,
  output rec_t              pop_rec,
  output logic [QCNT_W-1:0] count
);

  rec_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign pop_rec = entry[rd_ptr];

endmodule

### rtl/core/wbrn_front.sv
// Front end: takes samples, decides which ones are chosen, squares them and
// accumulates count, sum and sum of squares; pushes one record per waveform.
// Depends on wbrn_pkg (cfg_t, rec_t, widths).
module wbrn_front import wbrn_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic [TIME_BITS-1:0]          sample_time,
  input  logic                          end_of_waveform,
  input  logic [QCNT_W-1:0]             queue_count,
  output logic                          push,
  output rec_t                          push_rec
);

  logic [CNT_W-1:0] position;
  logic [CNT_W-1:0] chosen_count;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] position_inc;
  logic             chosen;
  logic             use_it;
  logic             accept;

  // stage a: classified sample
  logic                          a_valid;
  logic signed [SAMPLE_BITS-1:0] a_value;
  logic                          a_use;
  logic                          a_last;
  logic [CNT_W-1:0]              a_count;
  logic                          a_short;

  // stage b: squared sample
  logic                          b_valid;
  logic signed [SAMPLE_BITS-1:0] b_value;
  logic [SQ_W-1:0]               b_square;
  logic                          b_last;
  logic [CNT_W-1:0]              b_count;
  logic                          b_short;

  logic signed [2*SAMPLE_BITS-1:0] square_full;

  // accumulators
  logic signed [S1_W-1:0] value_sum;
  logic [S2_W-1:0]        square_sum;
  logic signed [S1_W-1:0] value_sum_next;
  logic [S2_W-1:0]        square_sum_next;

  logic [QCNT_W-1:0] slots_taken;

  // every waveform end still in the pipe will need a queue slot
  assign slots_taken = queue_count + QCNT_W'(a_valid & a_last) + QCNT_W'(b_valid & b_last);
  assign s_tready    = slots_taken < QCNT_W'(QUEUE_DEPTH);
  assign accept      = s_tvalid & s_tready;

  always_comb begin
    limit = (cfg.first_count > MAX_COUNT) ? MAX_COUNT : cfg.first_count;
    if (cfg.select_mode == MODE_FIRST) begin
      chosen = position < limit;
    end else begin
      chosen = (cfg.window_start <= sample_time) && (sample_time <= cfg.window_end);
    end
    use_it       = chosen && (chosen_count < MAX_COUNT);
    position_inc = (position < MAX_COUNT) ? position + 1'b1 : position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      chosen_count <= '0;
      a_valid      <= 1'b0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        if (end_of_waveform) begin
          position     <= '0;
          chosen_count <= '0;
        end else begin
          position     <= position_inc;
          chosen_count <= chosen_count + CNT_W'(use_it);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_value <= sample_value;
      a_use   <= use_it;
      a_last  <= end_of_waveform;
      a_count <= chosen_count + CNT_W'(use_it);
      a_short <= (cfg.select_mode == MODE_FIRST) && (position_inc < limit);
    end
  end

  assign square_full = a_value * a_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      b_value  <= a_use ? a_value : '0;
      b_square <= a_use ? square_full[SQ_W-1:0] : '0;
      b_last   <= a_last;
      b_count  <= a_count;
      b_short  <= a_short;
    end
  end

  assign value_sum_next  = value_sum + {{(S1_W-SAMPLE_BITS){b_value[SAMPLE_BITS-1]}}, b_value};
  assign square_sum_next = square_sum + {{(S2_W-SQ_W){1'b0}}, b_square};

  always_ff @(posedge clk) begin
    if (rst) begin
      value_sum  <= '0;
      square_sum <= '0;
    end else if (b_valid) begin
      if (b_last) begin
        value_sum  <= '0;
        square_sum <= '0;
      end else begin
        value_sum  <= value_sum_next;
        square_sum <= square_sum_next;
      end
    end
  end

  assign push                = b_valid & b_last;
  assign push_rec.value_sum  = value_sum_next;
  assign push_rec.square_sum = square_sum_next;
  assign push_rec.count      = b_count;
  assign push_rec.short_wave = b_short;

endmodule

### rtl/core/wbrn_back.sv
// Back end: turns one waveform record into the rms result with split
// multiplies, a bit-serial divider and a bit-serial square root.
// Depends on wbrn_pkg (rec_t, widths, status codes).
module wbrn_back import wbrn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [QCNT_W-1:0] queue_count,
  input  rec_t              pop_rec,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [RMS_W-1:0]  rms_noise,
  output logic [CNT_W-1:0]  used_count,
  output logic [1:0]        noise_status
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_A = 3'd1;
  localparam logic [2:0] ST_MUL_B = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_SUB   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_SQRT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam int S2_LO_W = 22;
  localparam int S2_HI_W = S2_W - S2_LO_W;
  localparam int MAG_W   = S1_W - 1;
  localparam int PROD_W  = 56;
  localparam int NUM_W   = 64;
  localparam int NN_W    = 25;
  localparam int STEP_W  = 6;

  logic [2:0]              state;
  logic [STEP_W-1:0]       step;
  logic [CNT_W-1:0]        n;
  logic [S2_W-1:0]         s2;
  logic [MAG_W-1:0]        s1_mag;
  logic                    short_wave;
  logic [CNT_W+S2_LO_W-1:0] p_lo;
  logic [CNT_W+S2_HI_W-1:0] p_hi;
  logic [NN_W-1:0]         nn;
  logic [2*MAG_W-1:0]      s1_sq;
  logic [PROD_W-1:0]       prod;
  logic [NUM_W-1:0]        num;
  logic [NN_W-1:0]         rem;
  logic [NUM_W-1:0]        root;
  logic [NUM_W-1:0]        root_bit;

  logic signed [S1_W-1:0]  s1_abs;
  logic [2*CNT_W-1:0]      nn_full;
  logic [PROD_W:0]         diff;
  logic [NN_W:0]           rem_shift;
  logic                    div_fits;
  logic [NUM_W-1:0]        trial;
  logic                    out_free;

  assign s1_abs    = pop_rec.value_sum[S1_W-1] ? -pop_rec.value_sum : pop_rec.value_sum;
  assign nn_full   = n * n;
  assign diff      = {1'b0, prod} - {{(PROD_W-2*MAG_W+1){1'b0}}, s1_sq};
  assign rem_shift = {rem, num[NUM_W-1]};
  assign div_fits  = rem_shift >= {1'b0, nn};
  assign trial     = root + root_bit;
  assign out_free  = !m_tvalid || m_tready;
  assign pop       = (state == ST_IDLE) && (queue_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE:  if (pop) state <= ST_MUL_A;
        ST_MUL_A: state <= (n == '0) ? ST_DONE : ST_MUL_B;
        ST_MUL_B: state <= ST_ADD;
        ST_ADD:   state <= ST_SUB;
        ST_SUB:   state <= ST_DIV;
        ST_DIV:   if (step == '0) state <= ST_SQRT;
        ST_SQRT:  if (step == '0) state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop) begin
          n          <= pop_rec.count;
          s2         <= pop_rec.square_sum;
          s1_mag     <= s1_abs[MAG_W-1:0];
          short_wave <= pop_rec.short_wave;
        end
      end
      ST_MUL_A: begin
        p_lo <= n * s2[S2_LO_W-1:0];
        nn   <= nn_full[NN_W-1:0];
        root <= '0;
      end
      ST_MUL_B: begin
        p_hi  <= n * s2[S2_W-1:S2_LO_W];
        s1_sq <= s1_mag * s1_mag;
      end
      ST_ADD: begin
        prod <= {p_hi[PROD_W-S2_LO_W-1:0], {S2_LO_W{1'b0}}}
              + {{(PROD_W-CNT_W-S2_LO_W){1'b0}}, p_lo};
      end
      ST_SUB: begin
        // a negative difference is clamped to zero, then scaled by 256 for Q4
        num  <= diff[PROD_W] ? '0 : {diff[PROD_W-1:0], 8'b0};
        rem  <= '0;
        step <= STEP_W'(NUM_W - 1);
      end
      ST_DIV: begin
        // restoring division, quotient bits shift in where numerator bits leave
        rem  <= div_fits ? NN_W'(rem_shift - {1'b0, nn}) : rem_shift[NN_W-1:0];
        num  <= {num[NUM_W-2:0], div_fits};
        step <= step - 1'b1;
        if (step == '0) begin
          root     <= '0;
          root_bit <= {2'b01, {(NUM_W-2){1'b0}}};
          step     <= STEP_W'(NUM_W/2 - 1);
        end
      end
      ST_SQRT: begin
        if (num >= trial) begin
          num  <= num - trial;
          root <= (root >> 1) + root_bit;
        end else begin
          root <= root >> 1;
        end
        root_bit <= root_bit >> 2;
        step     <= step - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          rms_noise  <= (root > {{(NUM_W-RMS_W){1'b0}}, RMS_MAX}) ? RMS_MAX : root[RMS_W-1:0];
          used_count <= n;
          if (n == '0)      noise_status <= STATUS_EMPTY;
          else if (short_wave) noise_status <= STATUS_SHORT;
          else              noise_status <= STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/waveform_baseline_rms_noise.sv
// Top level of the waveform baseline rms noise block: configuration
// registers on an APB-style port, front end, record queue and back end.
// Depends on wbrn_pkg, wbrn_front, wbrn_queue, wbrn_back.
//
// Usage:
//   Samples enter on the s_ channel, one transfer per cycle while s_tready is high;
//   s_tlast marks the final sample of a waveform. For each waveform one
//   result leaves on the m_ channel: rms noise in Q4 and the number of
//   samples used in m_tdata, the status code in m_tuser.
//   Result path: after the last sample's transfer, the record passes the
//   2 front stages, the queue, the multiply/add/subtract steps, a bit-serial
//   divide and a bit-serial square root; divide and root are skipped when none chosen.
//   Throughput: one sample per cycle while s_tready is high; the back end takes
//   one waveform at a time, so waveform records are buffered in a
//   four-entry record queue; when it fills, s_tready drops.
//   Reset clears all counters, accumulators, the queue and the output valid, and
//   loads the register defaults (mode 0, count 100, full time window).
//   When the receiver stalls, the result holds on m_tdata/m_tuser, the back
//   end waits, and sample intake continues until the queue is full.
//   Registers must be written only while no waveform is in progress; the block does not enforce it.
module waveform_baseline_rms_noise import wbrn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [15:0] sample_value, [47:16] sample_time
  input  logic        s_tlast,   // end_of_waveform
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [18:0] rms_noise, [31:19] used_count
  output logic [1:0]  m_tuser    // [1:0] noise_status
);

  cfg_t              cfg;
  logic              cfg_write;
  logic [1:0]        reg_index;
  logic [QCNT_W-1:0] queue_count;
  logic              push;
  rec_t              push_rec;
  logic              pop;
  rec_t              pop_rec;
  logic [RMS_W-1:0]  rms_noise;
  logic [CNT_W-1:0]  used_count;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.select_mode  <= MODE_FIRST;
      cfg.first_count  <= CNT_W'(100);
      cfg.window_start <= '0;
      cfg.window_end   <= '1;
    end else if (cfg_write) begin
      case (reg_index)
        REG_MODE:  cfg.select_mode  <= pwdata[0];
        REG_FIRST: cfg.first_count  <= pwdata[CNT_W-1:0];
        REG_START: cfg.window_start <= pwdata[TIME_BITS-1:0];
        REG_END:   cfg.window_end   <= pwdata[TIME_BITS-1:0];
        default:   cfg.select_mode  <= cfg.select_mode;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_MODE:  prdata = {31'b0, cfg.select_mode};
      REG_FIRST: prdata = {{(32-CNT_W){1'b0}}, cfg.first_count};
      REG_START: prdata = cfg.window_start;
      REG_END:   prdata = cfg.window_end;
      default:   prdata = '0;
    endcase
  end

  wbrn_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .sample_value    (s_tdata[SAMPLE_BITS-1:0]),
    .sample_time     (s_tdata[SAMPLE_BITS+TIME_BITS-1:SAMPLE_BITS]),
    .end_of_waveform (s_tlast),
    .queue_count     (queue_count),
    .push            (push),
    .push_rec        (push_rec)
  );

  wbrn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .count    (queue_count)
  );

  wbrn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_count  (queue_count),
    .pop_rec      (pop_rec),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .rms_noise    (rms_noise),
    .used_count   (used_count),
    .noise_status (m_tuser)
  );

  assign m_tdata = {used_count, rms_noise};

endmodule
